// ===== hw/rtl/cse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the C string escape encoder
// Holds the beat structures, the classified descriptor passed from the
// front end to the serializer, and the character helper functions.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] ESC_CHAR  = 8'h5c;
    localparam logic [7:0] CTRL_MAX  = 8'h1f;
    localparam logic [7:0] DEL_CHAR  = 8'h7f;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_beat;

    // How the serializer expands one descriptor.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PLAIN,
        KIND_SHORT,
        KIND_HEX
    } t_kind;

    // data holds the byte itself (plain), the escape letter (short) or the
    // raw control byte (hex).
    typedef struct packed {
        logic       rel_bs;
        t_kind      kind;
        logic [7:0] data;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] short_letter(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h00:   r = 8'h30;  // '0'
            8'h07:   r = 8'h61;  // 'a'
            8'h08:   r = 8'h62;  // 'b'
            8'h09:   r = 8'h74;  // 't'
            8'h0a:   r = 8'h6e;  // 'n'
            8'h0b:   r = 8'h76;  // 'v'
            8'h0c:   r = 8'h66;  // 'f'
            8'h0d:   r = 8'h72;  // 'r'
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h57 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic logic [2:0] kind_len(input t_kind k);
        logic [2:0] r;
        unique case (k)
            KIND_NONE:  r = 3'd0;
            KIND_PLAIN: r = 3'd1;
            KIND_SHORT: r = 3'd2;
            KIND_HEX:   r = 3'd4;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/cse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_front: input classifier
// Classifies each accepted byte, tracks the held backslash and pushes one
// descriptor per item that produces output.
// ----------------------------------------------------------------------------
module cse_front
    import cse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_desc     o_desc
);

    logic       r_pending;
    logic       n_pending;
    logic       accept;
    logic       is_ctrl;
    logic [7:0] c;
    logic [7:0] letter;
    t_desc      desc;

    assign c          = i_in_beat.in_byte;
    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_ctrl    = (c <= CTRL_MAX) || (c == DEL_CHAR);
    assign letter     = short_letter(c);

    always_comb begin
        desc.rel_bs = r_pending && !is_ctrl;
        desc.data   = c;
        if (c == ESC_CHAR) begin
            desc.kind = KIND_NONE;
        end else if (letter != 8'h00) begin
            desc.kind = KIND_SHORT;
            desc.data = letter;
        end else if (is_ctrl) begin
            desc.kind = KIND_HEX;
        end else begin
            desc.kind = KIND_PLAIN;
        end
    end

    // A backslash is held unless it closes the string; any other byte clears it.
    assign n_pending = (c == ESC_CHAR) ? !i_in_beat.end_of_string : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

    assign o_push = accept && (desc.rel_bs || (desc.kind != KIND_NONE));
    assign o_desc = desc;

endmodule

// ===== hw/rtl/cse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_queue: descriptor queue
// Small register queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module cse_queue
    import cse_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc     i_desc,
    input  logic      i_pop,
    output t_desc     o_head,
    output t_q_status o_status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/cse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_back: output serializer
// Expands the head descriptor into escaped bytes, one per cycle unless the
// output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module cse_back
    import cse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_desc     i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic [2:0] r_idx;
    logic       r_valid;
    t_out_beat  r_beat;
    logic [2:0] len;
    logic [2:0] k;
    logic [7:0] cur_byte;
    logic       is_last;
    logic       load;

    assign len     = {2'b00, i_head.rel_bs} + kind_len(i_head.kind);
    assign k       = r_idx - {2'b00, i_head.rel_bs};
    assign is_last = (r_idx == len - 3'd1);
    assign load    = !i_q_status.empty && (!r_valid || i_out_ready);
    assign o_pop   = load && is_last;

    always_comb begin
        cur_byte = ESC_CHAR;
        if (!(i_head.rel_bs && (r_idx == 3'd0))) begin
            case (i_head.kind)
                KIND_PLAIN: cur_byte = i_head.data;
                KIND_SHORT: cur_byte = (k == 3'd0) ? ESC_CHAR : i_head.data;
                KIND_HEX: begin
                    case (k)
                        3'd0:    cur_byte = ESC_CHAR;
                        3'd1:    cur_byte = CHAR_X;
                        3'd2:    cur_byte = hex_digit(i_head.data[7:4]);
                        default: cur_byte = hex_digit(i_head.data[3:0] & NIBBLE_MASK);
                    endcase
                end
                default:    cur_byte = ESC_CHAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat.out_byte    <= cur_byte;
            r_beat.last_of_run <= is_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

endmodule

// ===== hw/rtl/c_string_escape_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_escape_encoder_core: streaming C-style string escaper
// Turns raw string bytes into escaped text: short escapes for the common
// control codes, hex escapes for the rest and DEL, and a backslash that is
// held one beat and kept only when a printable byte follows it.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                  | Payload     | Beat carries
//  --------+----------------------------+-------------+-------------------------
//  in      | i_in_valid / o_in_ready    | i_in_beat   | one raw byte, end flag
//  out     | o_out_valid / i_out_ready  | o_out_beat  | one escaped byte, last
//
// The serializer emits one byte per cycle unless the output stalls; an item
// produces 1 byte for a plain byte, 2 for a short escape, 4 for a hex escape,
// plus 1 when a held backslash is released ahead of it. Items that produce
// nothing are consumed at the input and never reach the serializer.
// Reset is synchronous and active low; it clears the held backslash, the
// queue pointers and the output valid. Input stalls only when the descriptor
// queue is full; the output register lets a beat wait without blocking input.
//
module c_string_escape_encoder_core
    import cse_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    // Descriptor handed from the classifier to the queue.
    t_desc     push_desc;
    logic      push;
    // Head of the queue as seen by the serializer.
    t_desc     head_desc;
    logic      pop;
    t_q_status q_status;

    // Front end: classifies every accepted beat and keeps the held backslash.
    cse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_q_status (q_status),
        .o_push     (push),
        .o_desc     (push_desc)
    );

    // Queue lets the front keep accepting while a long escape drains.
    cse_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_head   (head_desc),
        .o_status (q_status)
    );

    // Back end: expands one descriptor into its bytes, one beat per cycle unless the output stalls.
    cse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_desc),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the C string escape encoder core
// Drives raw string bytes into the core and checks every escaped output
// beat against an in-bench prediction of the escaping rules. A directed
// table comes first, followed by randomized strings run under four
// idle/stall phases, one long receiver hold-off and a full drain between
// phases.
// ----------------------------------------------------------------------------
module tb_top;
    import cse_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int HOLD_CYCLES   = 80;
    localparam int TAIL_CYCLES   = 12;
    localparam int N_DIRECTED    = 25;

    // One row of the directed table. When typed is set, the n_gold bytes
    // of gold (first byte in the top bits) are the expected text for the
    // row. Otherwise the expected text comes from the escape predictor.
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        eos;
        logic        typed;
        logic [2:0]  n_gold;
        logic [31:0] gold;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_beat;

    // Escaped text still owed by the core, oldest byte first.
    t_out_beat escaped_q[$];
    t_out_beat want_beat;

    // Predictor state: a backslash is being held back for one beat.
    logic       bs_held = 1'b0;
    logic [7:0] esc_buf [0:4];

    int n_err          = 0;
    int n_sent         = 0;
    int cyc            = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // The main process bumps hold_ask to request a long receiver hold-off.
    // The receiver process notices the change and counts the hold itself.
    int hold_ask  = 0;
    int hold_seen = 0;
    int hold_cnt  = 0;

    t_dir_row dir_tab [0:N_DIRECTED-1] = '{
        // Plain byte, then every short escape.
        '{8'h41, 1'b0, 1'b1, 3'd1, {"A", 24'h0}},
        '{8'h00, 1'b0, 1'b1, 3'd2, {"\\0", 16'h0}},
        '{8'h07, 1'b0, 1'b1, 3'd2, {"\\a", 16'h0}},
        '{8'h08, 1'b0, 1'b1, 3'd2, {"\\b", 16'h0}},
        '{8'h09, 1'b0, 1'b1, 3'd2, {"\\t", 16'h0}},
        '{8'h0a, 1'b0, 1'b1, 3'd2, {"\\n", 16'h0}},
        '{8'h0b, 1'b0, 1'b1, 3'd2, {"\\v", 16'h0}},
        '{8'h0c, 1'b0, 1'b1, 3'd2, {"\\f", 16'h0}},
        '{8'h0d, 1'b0, 1'b1, 3'd2, {"\\r", 16'h0}},
        // Hex escapes at the edges of the control range, and DEL.
        '{8'h01, 1'b0, 1'b1, 3'd4, "\\x01"},
        '{8'h0e, 1'b0, 1'b1, 3'd4, "\\x0e"},
        '{8'h1f, 1'b0, 1'b1, 3'd4, "\\x1f"},
        '{8'h7f, 1'b0, 1'b1, 3'd4, "\\x7f"},
        // Lowest printable byte and the top of the byte range.
        '{8'h20, 1'b0, 1'b1, 3'd1, {" ", 24'h0}},
        '{8'hff, 1'b1, 1'b1, 3'd1, {8'hff, 24'h0}},
        // A held backslash released by a printable byte.
        '{8'h5c, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h7a, 1'b0, 1'b0, 3'd0, 32'h0},
        // A held backslash dropped by a control byte.
        '{8'h5c, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h1b, 1'b0, 1'b0, 3'd0, 32'h0},
        // Backslash after backslash, the second one ending the string.
        '{8'h5c, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h5c, 1'b1, 1'b0, 3'd0, 32'h0},
        '{8'h42, 1'b0, 1'b0, 3'd0, 32'h0},
        // A held backslash dropped by DEL.
        '{8'h5c, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h7f, 1'b0, 1'b0, 3'd0, 32'h0},
        // A lone backslash that ends the string yields nothing.
        '{8'h5c, 1'b1, 1'b1, 3'd0, 32'h0}
    };

    c_string_escape_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog. A hang anywhere in the run ends here.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d escaped bytes outstanding", $time,
                     escaped_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Lower-case hex digit for one nibble.
    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h61 + 8'(v) - 8'd10);
    endfunction

    // Escape predictor. Fills esc_buf with the text that one input beat
    // releases and returns its length; updates the held-backslash state.
    function automatic int escape_text(input t_in_beat b);
        logic [7:0] c;
        logic       ctrl;
        logic [7:0] letter;
        int         n;
        c    = b.in_byte;
        ctrl = (c <= CTRL_MAX) || (c == DEL_CHAR);
        n    = 0;
        // A held backslash survives only if a printable byte follows it.
        if (bs_held && !ctrl) begin
            esc_buf[n] = ESC_CHAR;
            n++;
        end
        bs_held = 1'b0;
        case (c)
            8'h00:   letter = "0";
            8'h07:   letter = "a";
            8'h08:   letter = "b";
            8'h09:   letter = "t";
            8'h0a:   letter = "n";
            8'h0b:   letter = "v";
            8'h0c:   letter = "f";
            8'h0d:   letter = "r";
            default: letter = 8'h00;
        endcase
        if (c == ESC_CHAR) begin
            // Held until the next beat decides, unless it ends the string.
            bs_held = !b.end_of_string;
        end else if (letter != 8'h00) begin
            esc_buf[n]   = ESC_CHAR;
            esc_buf[n+1] = letter;
            n += 2;
        end else if (ctrl) begin
            esc_buf[n]   = ESC_CHAR;
            esc_buf[n+1] = CHAR_X;
            esc_buf[n+2] = nibble_char(c[7:4]);
            esc_buf[n+3] = nibble_char(c[3:0]);
            n += 4;
        end else begin
            esc_buf[n] = c;
            n++;
        end
        return n;
    endfunction

    // Offers one input beat, with random idle cycles ahead of it, and
    // records the expected text once the core accepts it. Called and
    // returns at a falling edge; valid is left high for the caller to
    // follow with the next beat or to drop. A typed row supplies its own
    // text.
    task automatic offer(input t_in_beat b, input logic typed, input int n_gold,
                         input logic [31:0] gold);
        int n;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_beat  <= t_in_beat'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        n = escape_text(b);
        if (typed) begin
            n = n_gold;
            for (int k = 0; k < n; k++) begin
                esc_buf[k] = gold[31 - 8*k -: 8];
            end
        end
        for (int k = 0; k < n; k++) begin
            escaped_q.push_back('{out_byte: esc_buf[k], last_of_run: (k == n - 1)});
        end
        n_sent++;
        @(negedge i_clk);
    endtask

    // Byte mix for random strings: printable text is the largest share, with a healthy
    // share of control bytes, DEL, backslashes and bytes above 0x7f.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 8'($urandom_range(8'h7e, 8'h20));
        if (r < 52) return 8'($urandom_range(CTRL_MAX, 0));
        if (r < 58) return DEL_CHAR;
        if (r < 78) return ESC_CHAR;
        return 8'($urandom_range(8'hff, 8'h80));
    endfunction

    // Receiver: ready is redrawn at every falling edge, or held low for a
    // long stretch when the main process asks for one.
    always @(negedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_cnt  <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Output checker: every accepted beat must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (escaped_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                         $time, o_out_beat.out_byte, o_out_beat.last_of_run);
                n_err++;
            end else begin
                want_beat = escaped_q.pop_front();
                if (o_out_beat.out_byte !== want_beat.out_byte) begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, want_beat.out_byte, o_out_beat.out_byte);
                    n_err++;
                end
                if (o_out_beat.last_of_run !== want_beat.last_of_run) begin
                    $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                             $time, want_beat.last_of_run, o_out_beat.last_of_run);
                    n_err++;
                end
            end
        end
    end

    initial begin
        int str_len;
        int limit;
        t_in_beat b;

        // Synchronous reset, held for a fixed number of cycles.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, run with no idling on either side.
        for (int i = 0; i < N_DIRECTED; i++) begin
            b.in_byte       = dir_tab[i].in_byte;
            b.end_of_string = dir_tab[i].eos;
            offer(b, dir_tab[i].typed, int'(dir_tab[i].n_gold), dir_tab[i].gold);
        end

        // Random strings under four idle/stall phases. Each phase ends with
        // the sender paused until the core has delivered everything owed.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            limit = n_sent + ITEMS_PER_PHASE;
            // In the first phase the receiver goes quiet for a long stretch
            // while the sender keeps offering, so the core backs up.
            if (ph == 0) begin
                hold_ask++;
            end
            while (n_sent < limit) begin
                if ($urandom_range(99) < 12) begin
                    // Noise: any byte, any end flag.
                    b = t_in_beat'($urandom);
                    offer(b, 1'b0, 0, 32'h0);
                end else begin
                    str_len = $urandom_range(8, 1);
                    for (int k = 0; k < str_len; k++) begin
                        b.in_byte       = pick_byte();
                        b.end_of_string = (k == str_len - 1);
                        offer(b, 1'b0, 0, 32'h0);
                    end
                end
            end
            i_in_valid <= 1'b0;
            while (escaped_q.size() != 0) @(negedge i_clk);
        end

        // Let any stray beat show up before the verdict.
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (escaped_q.size() != 0) begin
            $display("%0t: %0d escaped bytes never arrived", $time, escaped_q.size());
        end
        if (n_err == 0 && escaped_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
